// ===== hw/rtl/tte_pkg.sv =====
// Package for the tap tempo estimator: field widths and arithmetic constants.
// Used by tte_click_unit, tte_tempo_unit and tap_tempo_estimator.
// No dependencies.
`default_nettype none
package tte_pkg;

  localparam int TICK_W   = 32;
  localparam int TIME_W   = 32;
  localparam int TPQ_W    = 15;
  localparam int CPC_W    = 8;
  localparam int TEMPO_W  = 24;
  localparam int STAT_W   = 8;
  localparam int DATA_W   = 7;
  localparam int KIND_W   = 7;
  localparam int LEN_W    = 8;

  localparam int CLK_PER_QTR = 24;
  localparam int MS_TO_US    = 1000;
  localparam int US_FACTOR   = MS_TO_US * CLK_PER_QTR;
  localparam int K_W         = $clog2(US_FACTOR + 1);
  localparam int PROD_W      = TIME_W + K_W;
  localparam int CT_W        = TPQ_W + CPC_W;

  localparam logic [TPQ_W-1:0]   TPQ_RST  = TPQ_W'(96);
  localparam logic [CPC_W-1:0]   CPC_RST  = CPC_W'(CLK_PER_QTR);
  localparam logic [TEMPO_W-1:0] TEMPO_MAX = '1;

  localparam logic [3:0]        NIB_NOTE_ON = 4'h9;
  localparam logic [3:0]        NIB_CTRL    = 4'hB;
  localparam logic [KIND_W-1:0] KIND_TSIG   = KIND_W'(8'h58);
  localparam logic [LEN_W-1:0]  LEN_TSIG    = LEN_W'(4);

endpackage
`default_nettype wire

// ===== hw/rtl/tte_click_unit.sv =====
// Bit-serial click length unit: ticks_per_quarter * clocks_per_click / 24.
// Shift-add multiply, then restoring divide by the constant, one bit per cycle.
// Depends on tte_pkg.
`default_nettype none
module tte_click_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tte_pkg::TPQ_W-1:0] tpq,
  input  wire logic [tte_pkg::CPC_W-1:0] cpc,
  output logic                           busy,
  output logic [tte_pkg::CT_W-1:0]       click_ticks
);
  import tte_pkg::*;

  localparam int CNT_W = $clog2(CT_W);
  localparam int REM_W = $clog2(CLK_PER_QTR);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CT_W-1:0]  acc_r, acc_nxt;
  logic [CT_W-1:0]  mcand_r, mcand_nxt;
  logic [CPC_W-1:0] mlt_r, mlt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, acc_r[CT_W-1]};
  assign ge    = trial >= (REM_W+1)'(CLK_PER_QTR);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mlt_nxt   = mlt_r;
    rem_nxt   = rem_r;
    unique case (phase_r)
      PH_MUL: begin
        if (mlt_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = {mcand_r[CT_W-2:0], 1'b0};
        mlt_nxt   = {1'b0, mlt_r[CPC_W-1:1]};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CPC_W-1)) begin
          phase_nxt = PH_DIV;
          cnt_nxt   = '0;
          rem_nxt   = '0;
        end
      end
      PH_DIV: begin
        rem_nxt = ge ? REM_W'(trial - (REM_W+1)'(CLK_PER_QTR)) : trial[REM_W-1:0];
        acc_nxt = {acc_r[CT_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CT_W-1)) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (start) begin
          phase_nxt = PH_MUL;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          mcand_nxt = CT_W'(tpq);
          mlt_nxt   = cpc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mlt_r   <= mlt_nxt;
    rem_r   <= rem_nxt;
  end

  assign busy        = phase_r != PH_IDLE;
  assign click_ticks = acc_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tte_tempo_unit.sv =====
// Bit-serial tempo unit: elapsed_ms * 24000 / clocks_per_click, saturated.
// Shift-add multiply by the constant, then restoring divide, one bit per cycle.
// Depends on tte_pkg.
`default_nettype none
module tte_tempo_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tte_pkg::TIME_W-1:0]  diff,
  input  wire logic [tte_pkg::CPC_W-1:0]   cpc,
  output logic                             busy,
  output logic [tte_pkg::TEMPO_W-1:0]      tempo
);
  import tte_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [CPC_W-1:0]  dvs_r, dvs_nxt;
  logic [CPC_W-1:0]  rem_r, rem_nxt;
  logic [CPC_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, acc_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    k_nxt     = k_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    unique case (phase_r)
      PH_MUL: begin
        if (k_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = {mcand_r[PROD_W-2:0], 1'b0};
        k_nxt     = {1'b0, k_r[K_W-1:1]};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(K_W-1)) begin
          phase_nxt = PH_DIV;
          cnt_nxt   = '0;
          rem_nxt   = '0;
        end
      end
      PH_DIV: begin
        rem_nxt = ge ? CPC_W'(trial - {1'b0, dvs_r}) : trial[CPC_W-1:0];
        acc_nxt = {acc_r[PROD_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W-1)) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (start) begin
          phase_nxt = PH_MUL;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          mcand_nxt = PROD_W'(diff);
          k_nxt     = K_W'(US_FACTOR);
          dvs_nxt   = cpc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    k_r     <= k_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
  end

  assign busy  = phase_r != PH_IDLE;
  assign tempo = (|acc_r[PROD_W-1:TEMPO_W]) ? TEMPO_MAX : acc_r[TEMPO_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/tap_tempo_estimator.sv =====
// Tap tempo estimator top level: decode, tap state, output register.
// Depends on tte_pkg, tte_click_unit, tte_tempo_unit.
//
//   channel  | handshake           | payload
//   in       | in_valid/in_ready   | mode, status, data2, timestamp, meta kind/len, cpc
//   out      | out_valid/out_ready | tempo_tick, apply_tick, tempo_us
//   cfg      | cfg_we              | ticks_per_quarter
//
// An item that is not a tap or a valid time signature is accepted without leaving the idle state.
// A time signature or first tap runs the click unit alone (8-bit multiply, 23-bit divide).
// A later tap is paced by the 15-bit multiply and 47-bit divide
// of the tempo unit; the click unit runs alongside.
// A waiting result holds any tap or time signature at its last cycle until it leaves.
// Reset is synchronous; no clearing pass.
`default_nettype none
module tap_tempo_estimator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tte_pkg::TPQ_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_mode,
  input  wire logic [tte_pkg::STAT_W-1:0]   in_status_byte,
  input  wire logic [tte_pkg::DATA_W-1:0]   in_second_data,
  input  wire logic [tte_pkg::TIME_W-1:0]   in_timestamp_ms,
  input  wire logic [tte_pkg::KIND_W-1:0]   in_meta_kind,
  input  wire logic [tte_pkg::LEN_W-1:0]    in_meta_length,
  input  wire logic [tte_pkg::CPC_W-1:0]    in_clocks_per_click,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tte_pkg::TICK_W-1:0]        out_tempo_tick,
  output logic [tte_pkg::TICK_W-1:0]        out_apply_tick,
  output logic [tte_pkg::TEMPO_W-1:0]       out_tempo_us
);
  import tte_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  localparam logic [1:0] OP_TSIG = 2'd0;
  localparam logic [1:0] OP_ARM  = 2'd1;
  localparam logic [1:0] OP_TAP  = 2'd2;

  logic              state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [TPQ_W-1:0]  tpq_r;
  logic              armed_r;
  logic [TICK_W-1:0] cur_r, next_r;
  logic [TIME_W-1:0] last_r;
  logic [CPC_W-1:0]  cc_r;
  logic              out_valid_r;
  logic [TICK_W-1:0] out_tempo_tick_r, out_apply_tick_r;
  logic [TEMPO_W-1:0] out_tempo_us_r;

  logic              accept, tsig_hit, tap_hit, fin, emit;
  logic              clk_start, tmp_start, clk_busy, tmp_busy;
  logic [CT_W-1:0]   ct;
  logic [TICK_W-1:0] ct_ext;
  logic [TEMPO_W-1:0] tempo;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign tsig_hit = in_mode && in_meta_kind == KIND_TSIG && in_meta_length == LEN_TSIG
                    && in_clocks_per_click != '0;
  assign tap_hit  = !in_mode && in_second_data != '0
                    && (in_status_byte[STAT_W-1 -: 4] == NIB_NOTE_ON
                        || in_status_byte[STAT_W-1 -: 4] == NIB_CTRL);
  assign clk_start = accept && (tsig_hit || tap_hit);
  assign tmp_start = accept && tap_hit && armed_r;

  tte_click_unit u_click (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (clk_start),
    .tpq         (tpq_r),
    .cpc         (tsig_hit ? in_clocks_per_click : cc_r),
    .busy        (clk_busy),
    .click_ticks (ct)
  );

  tte_tempo_unit u_tempo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tmp_start),
    .diff  (in_timestamp_ms - last_r),
    .cpc   (cc_r),
    .busy  (tmp_busy),
    .tempo (tempo)
  );

  assign ct_ext = TICK_W'(ct);
  assign fin    = state_r == S_CALC && !clk_busy && !tmp_busy
                  && (!out_valid_r || out_ready);
  assign emit   = fin && op_r == OP_TAP && tempo != '0;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (clk_start) begin
          state_nxt = S_CALC;
          op_nxt    = tsig_hit ? OP_TSIG : (armed_r ? OP_TAP : OP_ARM);
        end
      end
      S_CALC: begin
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TSIG;
      tpq_r       <= TPQ_RST;
      armed_r     <= 1'b0;
      cur_r       <= '0;
      next_r      <= '0;
      last_r      <= '0;
      cc_r        <= CPC_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cfg_we) begin
        tpq_r <= cfg_wdata;
      end
      if (accept && tsig_hit) begin
        cc_r <= in_clocks_per_click;
      end
      if (accept && tap_hit) begin
        last_r <= in_timestamp_ms;
        if (!armed_r) begin
          armed_r <= 1'b1;
          cur_r   <= '0;
        end
      end
      if (fin) begin
        unique case (op_r)
          OP_TSIG: next_r <= cur_r + ct_ext;
          OP_ARM:  next_r <= ct_ext;
          default: begin
            cur_r  <= next_r;
            next_r <= next_r + ct_ext;
          end
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit) begin
      out_tempo_tick_r <= cur_r;
      out_apply_tick_r <= next_r;
      out_tempo_us_r   <= tempo;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tempo_tick = out_tempo_tick_r;
  assign out_apply_tick = out_apply_tick_r;
  assign out_tempo_us   = out_tempo_us_r;

  a_cc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r != '0)
    else $error("clocks per click reached zero");

  a_tap_starts_units: assert property (@(posedge clk) disable iff (!rst_n)
    tmp_start |=> clk_busy && tmp_busy && state_r == S_CALC)
    else $error("tap did not start both units");

  a_emit_from_tap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_CALC && $past(op_r) == OP_TAP)
    else $error("result without a completed tap");

  a_tempo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_tempo_us_r != '0)
    else $error("zero tempo sent");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (clk_busy || tmp_busy) |-> !in_ready)
    else $error("input taken while units busy");

endmodule
`default_nettype wire
